[src/pfsa_pkg.sv]
// Shared constants, types and state codes for the free page stack allocator.
package pfsa_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 1024;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Field widths fixed by the interface
    localparam int ADDR_W   = 32;
    localparam int SUM_W    = ADDR_W + 1;
    localparam int OFS_W    = 12;
    localparam int PAGE_W   = ADDR_W - OFS_W;
    localparam int TYPE_W   = 8;
    localparam int COUNT_W  = 11;
    localparam int CAP_W    = 11;
    localparam int CFG_IDX_W = 1;

    // Address constants
    localparam logic [ADDR_W-1:0] LOW_MEM_LIMIT  = 32'h0010_0000;
    localparam logic [SUM_W-1:0]  ADDR_SPACE_END = 33'h1_0000_0000;
    localparam logic [SUM_W-1:0]  PAGE_STEP      = 33'h0_0000_1000;
    localparam logic [TYPE_W-1:0] TYPE_RAM       = 8'd1;
    localparam logic [CAP_W-1:0]  CAP_RESET      = CAP_W'(STACK_DEPTH);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD_REGION = 2'd0,
        OP_FREE       = 2'd1,
        OP_ALLOC      = 2'd2,
        OP_NOP        = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_KEND,
        S_START,
        S_WALK,
        S_PUSH,
        S_POP_RD,
        S_DONE
    } state_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [ADDR_W-1:0]   region_base;
        logic [ADDR_W-1:0]   region_length;
        logic [TYPE_W-1:0]   region_type;
        logic [ADDR_W-1:0]   freed_page_addr;
    } request_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   page_addr;
        status_t             status;
        logic [COUNT_W-1:0]  free_count;
    } result_t;

endpackage

[src/pfsa_ram.sv]
// Simple dual-port RAM with one write port and one registered read port.
module pfsa_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 20
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/pfsa_core.sv]
// Sequencer and shared add/compare datapath that runs one request to completion.
module pfsa_core
    import pfsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  request_t            req,
    input  logic [ADDR_W-1:0]   kernel_end,
    input  logic [CAP_W-1:0]    capacity,
    input  logic                res_take,
    output logic                ready,
    output logic                done,
    output result_t             res
);

    state_t             state_reg, state_next;
    request_t           req_reg, req_next;
    status_t            status_reg, status_next;
    logic               pop_ok_reg, pop_ok_next;
    logic [CNT_W-1:0]   top_reg, top_next;
    logic [SUM_W-1:0]   end_reg, end_next;
    logic [SUM_W-1:0]   kend_reg, kend_next;
    logic [SUM_W-1:0]   addr_reg, addr_next;

    // Shared unit operands and results
    logic [SUM_W-1:0]   alu_a, alu_b, alu_sum;
    logic [SUM_W-1:0]   cmp_a, cmp_b;
    logic               cmp_lt;

    logic [CNT_W-1:0]   eff_cap;
    logic               full;
    logic               usable;

    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [PAGE_W-1:0]  ram_wdata, ram_rdata;

    pfsa_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (PAGE_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Shared adder and comparator
    assign alu_sum = alu_a + alu_b;
    assign cmp_lt  = cmp_a < cmp_b;

    // Clamp capacity to the store depth and test for a full stack
    assign eff_cap = (32'(capacity) > 32'(STACK_DEPTH)) ? CNT_W'(STACK_DEPTH)
                                                        : CNT_W'(capacity);
    assign full    = 32'(top_reg) >= 32'(eff_cap);
    assign usable  = (req_reg.region_type == TYPE_RAM) &&
                     (req_reg.region_base >= LOW_MEM_LIMIT);

    // Select operands of the shared unit
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        cmp_a = '0;
        cmp_b = '0;
        unique case (state_reg)
            S_DECODE:
            begin
                alu_a = {1'b0, req_reg.region_base};
                alu_b = {1'b0, req_reg.region_length};
            end
            S_KEND:
            begin
                alu_a = {1'b0, kernel_end[ADDR_W-1:OFS_W], {OFS_W{1'b0}}};
                alu_b = PAGE_STEP;
            end
            S_START:
            begin
                cmp_a = {1'b0, req_reg.region_base};
                cmp_b = kend_reg;
            end
            S_WALK:
            begin
                alu_a = addr_reg;
                alu_b = PAGE_STEP;
                cmp_a = addr_reg;
                cmp_b = end_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (req.opcode)
                        OP_ADD_REGION: state_next = S_DECODE;
                        OP_FREE:       state_next = S_PUSH;
                        OP_ALLOC:      state_next = S_POP_RD;
                        OP_NOP:        state_next = S_DONE;
                        default:       state_next = S_DONE;
                    endcase
                end
            end
            S_DECODE: state_next = usable ? S_KEND : S_DONE;
            S_KEND:   state_next = S_START;
            S_START:  state_next = S_WALK;
            S_WALK:
            begin
                if (!cmp_lt || full)
                begin
                    state_next = S_DONE;
                end
            end
            S_PUSH:   state_next = S_DONE;
            S_POP_RD: state_next = S_DONE;
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Datapath updates and store access
    always_comb
    begin
        req_next    = req_reg;
        status_next = status_reg;
        pop_ok_next = pop_ok_reg;
        top_next    = top_reg;
        end_next    = end_reg;
        kend_next   = kend_reg;
        addr_next   = addr_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = top_reg[IDX_W-1:0];
        ram_wdata   = addr_reg[ADDR_W-1:OFS_W];
        ram_raddr   = IDX_W'(top_reg - CNT_W'(1));
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = req;
                    status_next = ST_OK;
                    pop_ok_next = 1'b0;
                end
            end
            S_DECODE:
            begin
                // Clip the region end at the top of the address space
                end_next = (alu_sum > ADDR_SPACE_END) ? ADDR_SPACE_END : alu_sum;
            end
            S_KEND:
            begin
                kend_next = alu_sum;
            end
            S_START:
            begin
                addr_next = cmp_lt ? kend_reg : {1'b0, req_reg.region_base};
            end
            S_WALK:
            begin
                if (cmp_lt)
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        top_next  = top_reg + CNT_W'(1);
                        addr_next = alu_sum;
                    end
                end
            end
            S_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = req_reg.freed_page_addr[ADDR_W-1:OFS_W];
                    top_next  = top_reg + CNT_W'(1);
                end
            end
            S_POP_RD:
            begin
                if (top_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    ram_re      = 1'b1;
                    top_next    = top_reg - CNT_W'(1);
                    pop_ok_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            top_reg    <= '0;
            pop_ok_reg <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            top_reg    <= top_next;
            pop_ok_reg <= pop_ok_next;
            status_reg <= status_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        end_reg  <= end_next;
        kend_reg <= kend_next;
        addr_reg <= addr_next;
    end

    // Drive handshake and result
    assign ready          = (state_reg == S_IDLE);
    assign done           = (state_reg == S_DONE);
    assign res.page_addr  = pop_ok_reg ? {ram_rdata, {OFS_W{1'b0}}} : '0;
    assign res.status     = status_reg;
    assign res.free_count = COUNT_W'(top_reg);

endmodule

[src/page_frame_stack_allocator.sv]
// Top level of the free page stack allocator: ports, configuration and result register.
//
// Usage: a request enters on in_valid/in_stall with opcode and its fields.
// Opcode 0 offers a memory-map region whose usable 4 KiB pages are pushed,
// opcode 1 pushes one freed page, opcode 2 pops one page, opcode 3 does nothing.
// Every request yields exactly one result on out_valid/out_stall carrying
// page_addr, status (ok, full, empty) and free_count.
// A usable region is decoded, its end is computed and clipped, the first page after
// the kernel end is found and the walk start is chosen; the walk then pushes one
// page per cycle through the shared adder and comparator and the single write port
// of the page store.
// One request is worked on at a time; in_stall is high until the result has
// been moved into the output register, which may still hold an untaken result
// while the next request is accepted.
// If out_stall is high while out_valid is high, the result is held unchanged
// and a finished request waits in its final state, keeping in_stall high.
// Reset empties the stack, sets kernel_end_addr to 0 and stack_capacity to
// 1024; the page store is not cleared and needs no clearing pass.
// Configuration writes go through cfg_wr_en, cfg_index and cfg_data; the user
// must make them only while idle, as the block itself does not enforce this.
module page_frame_stack_allocator
    import pfsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            opcode,
    input  logic [ADDR_W-1:0]     region_base,
    input  logic [ADDR_W-1:0]     region_length,
    input  logic [TYPE_W-1:0]     region_type,
    input  logic [ADDR_W-1:0]     freed_page_addr,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ADDR_W-1:0]     page_addr,
    output logic [1:0]            status,
    output logic [COUNT_W-1:0]    free_count,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_W-1:0]     cfg_data
);

    logic [ADDR_W-1:0]  kernel_end_reg;
    logic [CAP_W-1:0]   capacity_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            res_reg;
    result_t            core_res;
    request_t           req;
    logic               core_ready, core_done;
    logic               res_take, start;

    assign req.opcode          = opcode_t'(opcode);
    assign req.region_base     = region_base;
    assign req.region_length   = region_length;
    assign req.region_type     = region_type;
    assign req.freed_page_addr = freed_page_addr;

    assign in_stall = !core_ready;
    assign start    = in_valid && core_ready;
    assign res_take = !out_valid_reg || !out_stall;

    pfsa_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .kernel_end (kernel_end_reg),
        .capacity   (capacity_reg),
        .res_take   (res_take),
        .ready      (core_ready),
        .done       (core_done),
        .res        (core_res)
    );

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_end_reg <= '0;
            capacity_reg   <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_KERNEL_END: kernel_end_reg <= cfg_data;
                CFG_CAPACITY:   capacity_reg   <= cfg_data[CAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (core_done && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (core_done && res_take)
        begin
            res_reg <= core_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign page_addr  = res_reg.page_addr;
    assign status     = res_reg.status;
    assign free_count = res_reg.free_count;

    // An accepted request blocks further requests in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request accepted while previous one still in progress");

    // A nonzero page is only returned with an ok status
    a_page_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (page_addr != '0)) |-> (status == ST_OK))
        else $error("page returned with error status");

    // An empty report always comes with an empty stack
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY)) |-> (free_count == '0))
        else $error("empty status with nonzero free count");

    // Returned pages are page aligned
    a_page_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (page_addr[OFS_W-1:0] == '0))
        else $error("unaligned page returned");

endmodule

[dv/page_frame_stack_allocator_test.sv]
// Self-checking testbench for the free page stack allocator: directed and random requests.
module page_frame_stack_allocator_test;
    import pfsa_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 8000;
    localparam int HOLD_CYCLES   = 400;

    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 in_valid        = 1'b0;
    logic                 in_stall;
    logic [1:0]           opcode          = OP_NOP;
    logic [ADDR_W-1:0]    region_base     = '0;
    logic [ADDR_W-1:0]    region_length   = '0;
    logic [TYPE_W-1:0]    region_type     = '0;
    logic [ADDR_W-1:0]    freed_page_addr = '0;
    logic                 out_valid;
    logic                 out_stall       = 1'b0;
    logic [ADDR_W-1:0]    page_addr;
    logic [1:0]           status;
    logic [COUNT_W-1:0]   free_count;
    logic                 cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index       = CFG_KERNEL_END;
    logic [ADDR_W-1:0]    cfg_data        = '0;

    // Shadow copy of the allocator state and its registers
    logic [PAGE_W-1:0]    shadow_pages [STACK_DEPTH];
    int unsigned          shadow_top        = 0;
    logic [ADDR_W-1:0]    shadow_kernel_end = '0;
    logic [CAP_W-1:0]     shadow_capacity   = CAP_RESET;

    result_t              expected_page_results [$];
    int                   mismatches     = 0;
    int                   quiet_cycles   = 0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int                   hold_left      = 0;

    page_frame_stack_allocator dut (.*);

    always #5 clk = ~clk;

    // Work out the result of one request and advance the shadow stack
    function automatic result_t predict_stack_op(input opcode_t op, input logic [31:0] base,
                                                 input logic [31:0] len,
                                                 input logic [7:0] rtype,
                                                 input logic [31:0] freed);
        result_t     res;
        logic [32:0] first_page;
        logic [32:0] walk_addr;
        logic [32:0] walk_end;
        int unsigned cap_eff;
        res.page_addr = '0;
        res.status    = ST_OK;
        cap_eff = (shadow_capacity > STACK_DEPTH) ? STACK_DEPTH : shadow_capacity;
        case (op)
            OP_ADD_REGION:
            begin
                if (rtype == TYPE_RAM && base >= LOW_MEM_LIMIT)
                begin
                    // first page after the kernel, without wrap
                    first_page = ({1'b0, shadow_kernel_end} + PAGE_STEP) & ~33'h0_0000_0FFF;
                    walk_addr  = ({1'b0, base} > first_page) ? {1'b0, base} : first_page;
                    walk_end   = {1'b0, base} + {1'b0, len};
                    if (walk_end > ADDR_SPACE_END)
                        walk_end = ADDR_SPACE_END;
                    while (walk_addr < walk_end)
                    begin
                        if (shadow_top >= cap_eff)
                        begin
                            res.status = ST_FULL;
                            break;
                        end
                        shadow_pages[shadow_top] = walk_addr[ADDR_W-1:OFS_W];
                        shadow_top++;
                        walk_addr += PAGE_STEP;
                    end
                end
            end
            OP_FREE:
            begin
                if (shadow_top >= cap_eff)
                    res.status = ST_FULL;
                else
                begin
                    shadow_pages[shadow_top] = freed[ADDR_W-1:OFS_W];
                    shadow_top++;
                end
            end
            OP_ALLOC:
            begin
                if (shadow_top == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    shadow_top--;
                    res.page_addr = {shadow_pages[shadow_top], {OFS_W{1'b0}}};
                end
            end
            default:
            begin
            end
        endcase
        res.free_count = shadow_top[COUNT_W-1:0];
        return res;
    endfunction

    // Offer one request, hold it until accepted, then log its expected result
    task automatic send_request(input opcode_t op, input logic [31:0] base,
                                input logic [31:0] len, input logic [7:0] rtype,
                                input logic [31:0] freed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        opcode          <= op;
        region_base     <= base;
        region_length   <= len;
        region_type     <= rtype;
        freed_page_addr <= freed;
        do
            @(posedge clk);
        while (in_stall);
        expected_page_results.push_back(predict_stack_op(op, base, len, rtype, freed));
    endtask

    // Build a random request, mostly well-formed regions and balanced free/alloc
    task automatic send_random_request();
        opcode_t     op;
        logic [31:0] base;
        logic [31:0] len;
        logic [31:0] freed;
        logic [7:0]  rtype;
        int          pick;
        int          alloc_pct;
        int unsigned cap_eff;
        cap_eff = (shadow_capacity > STACK_DEPTH) ? STACK_DEPTH : shadow_capacity;
        base  = $urandom();
        len   = $urandom();
        rtype = 8'($urandom_range(0, 255));
        freed = $urandom();
        pick  = $urandom_range(99);
        if (pick < 4)
            op = OP_NOP;
        else if (pick < 26)
        begin
            op = OP_ADD_REGION;
            if ($urandom_range(99) < 85)
                rtype = TYPE_RAM;
            case ($urandom_range(9))
                0: base = $urandom_range(0, 32'h000F_FFFF);
                1: base = 32'h000F_F000 + $urandom_range(0, 32'h2000);
                2: base = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
                3, 4, 5: base = $urandom();
                default: base = shadow_kernel_end + $urandom_range(0, 32'h10000) - 32'h8000;
            endcase
            // keep most walks short, a few long enough to fill the stack
            pick = $urandom_range(99);
            if (pick < 3)
                len = $urandom();
            else if (pick < 8)
                len = '0;
            else
                len = $urandom_range(0, 32'h8000);
        end
        else
        begin
            alloc_pct = (shadow_top * 2 > cap_eff) ? 65 : 40;
            op = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
        end
        send_request(op, base, len, rtype, freed);
    endtask

    // Drop valid and wait until every result is back and the block is idle
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_page_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_KERNEL_END)
            shadow_kernel_end = data;
        else
            shadow_capacity = data[CAP_W-1:0];
        @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Empty stack, no-op, unaligned frees, unusable and clipped regions
    task automatic test_basic_ops();
        set_idling(0, 0);
        send_request(OP_ALLOC, '0, '0, '0, '0);
        send_request(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        send_request(OP_FREE, '0, '0, '0, 32'hFFFF_FFFF);
        send_request(OP_FREE, '0, '0, '0, 32'h0000_0000);
        send_request(OP_ALLOC, '0, '0, '0, '0);
        send_request(OP_ALLOC, '0, '0, '0, '0);
        send_request(OP_ADD_REGION, 32'h000F_FFFF, 32'h0001_0000, TYPE_RAM, '0);
        send_request(OP_ADD_REGION, 32'h0010_0000, 32'h0000_4000, 8'd2, '0);
        send_request(OP_ADD_REGION, 32'h0010_0000, 32'h0000_0000, TYPE_RAM, '0);
        send_request(OP_ADD_REGION, 32'h0010_0000, 32'h0000_3001, TYPE_RAM, '0);
        // region running past the top of the address space
        send_request(OP_ADD_REGION, 32'hFFFF_E000, 32'hFFFF_FFFF, TYPE_RAM, '0);
    endtask

    // Kernel end and capacity limits: empty walks, partial walks, full stack
    task automatic test_config_limits();
        settle_block();
        program_register(CFG_KERNEL_END, 32'h004F_FFFF);
        send_request(OP_ADD_REGION, 32'h0010_0000, 32'h0001_0000, TYPE_RAM, '0);
        send_request(OP_ADD_REGION, 32'h0040_0800, 32'h0010_2000, TYPE_RAM, '0);
        settle_block();
        program_register(CFG_CAPACITY, 32'd10);
        send_request(OP_ADD_REGION, 32'h0060_0000, 32'h0000_4000, TYPE_RAM, '0);
        send_request(OP_FREE, '0, '0, '0, 32'h1234_5678);
        // capacity below the current fill
        settle_block();
        program_register(CFG_CAPACITY, 32'd0);
        send_request(OP_FREE, '0, '0, '0, 32'h8765_4321);
        send_request(OP_ALLOC, '0, '0, '0, '0);
        settle_block();
        program_register(CFG_KERNEL_END, 32'hFFFF_FFFF);
        program_register(CFG_CAPACITY, STACK_DEPTH);
        send_request(OP_ADD_REGION, 32'h0010_0000, 32'hFFFF_FFFF, TYPE_RAM, '0);
        settle_block();
        program_register(CFG_KERNEL_END, 32'h0000_0000);
        send_request(OP_ADD_REGION, 32'h0010_0000, 32'hFFFF_FFFF, TYPE_RAM, '0);
        send_request(OP_FREE, '0, '0, '0, 32'h0ABC_D123);
        send_request(OP_ALLOC, '0, '0, '0, '0);
    endtask

    // Random traffic over several register settings and idling patterns
    task automatic test_random_traffic();
        logic [31:0] kend_set [6];
        logic [31:0] cap_set  [6];
        int          send_pcts  [4];
        int          stall_pcts [4];
        kend_set = '{32'h0000_0000, 32'h004F_FFFF, $urandom(), 32'hFFFF_FFFF,
                     32'h0012_3456, 32'h00FF_FFFF};
        cap_set  = '{STACK_DEPTH, 64, $urandom_range(1, STACK_DEPTH), 16, 0, 300};
        send_pcts  = '{0, 46, 0, 7};
        stall_pcts = '{0, 0, 46, 7};
        for (int s = 0; s < 6; s++)
        begin
            settle_block();
            program_register(CFG_KERNEL_END, kend_set[s]);
            program_register(CFG_CAPACITY, cap_set[s]);
            for (int m = 0; m < 4; m++)
            begin
                set_idling(send_pcts[m], stall_pcts[m]);
                repeat (70) send_random_request();
            end
        end
    endtask

    // Hold off the receiver long enough that the block stalls its input
    task automatic test_input_backpressure();
        settle_block();
        program_register(CFG_KERNEL_END, 32'h0000_0000);
        program_register(CFG_CAPACITY, STACK_DEPTH);
        set_idling(0, 0);
        hold_left = HOLD_CYCLES;
        repeat (40) send_random_request();
    endtask

    // Drive the result stall: long hold when asked, random otherwise
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each accepted result with the oldest expected one
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_page_results.size() == 0)
            begin
                $display("%0t: unexpected result page_addr %h status %0d free_count %0d",
                         $time, page_addr, status, free_count);
                mismatches++;
            end
            else
            begin
                want = expected_page_results.pop_front();
                if (page_addr !== want.page_addr)
                begin
                    $display("%0t: page_addr expected %h got %h",
                             $time, want.page_addr, page_addr);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, status);
                    mismatches++;
                end
                if (free_count !== want.free_count)
                begin
                    $display("%0t: free_count expected %0d got %0d",
                             $time, want.free_count, free_count);
                    mismatches++;
                end
            end
        end
    end

    // End the run if neither side moves a request for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_basic_ops();
        test_config_limits();
        test_random_traffic();
        test_input_backpressure();
        settle_block();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[page_frame_stack_allocator.f]
src/pfsa_pkg.sv
src/pfsa_ram.sv
src/pfsa_core.sv
src/page_frame_stack_allocator.sv
dv/page_frame_stack_allocator_test.sv
